// File: sv/utf8d_pkg.sv
`default_nettype none

package utf8d_pkg;

   // Field widths of the byte and result channels.
   localparam int TEXT_W  = 8;
   localparam int CP_W    = 21;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 9;
   localparam int DATA_W  = 32;

   // Replacement character emitted for malformed input.
   localparam logic [CP_W-1:0] REPL_CP = 21'h00fffd;

   // Lead byte masks and patterns.
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] CONT_MASK  = 8'hc0;
   localparam logic [7:0] CONT_PAT   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'he0;
   localparam logic [7:0] LEAD2_PAT  = 8'hc0;
   localparam logic [7:0] LEAD3_MASK = 8'hf0;
   localparam logic [7:0] LEAD3_PAT  = 8'he0;
   localparam logic [7:0] LEAD4_MASK = 8'hf8;
   localparam logic [7:0] LEAD4_PAT  = 8'hf0;

   // Payload bits kept from lead and continuation bytes.
   localparam logic [7:0] CONT_BITS  = 8'h3f;
   localparam logic [7:0] LEAD2_BITS = 8'h1f;
   localparam logic [7:0] LEAD3_BITS = 8'h0f;
   localparam logic [7:0] LEAD4_BITS = 8'h07;

   typedef struct packed {
      logic             end_marker_only;
      logic             end_of_text;
      logic [POS_W-1:0] position;
      logic [CP_W-1:0]  code_point;
   } result_type;

endpackage

`default_nettype wire

// File: sv/utf8_to_codepoint_decoder.sv
`default_nettype none

// UTF-8 decoder: takes one text byte per beat on the req_ channel, with
// req_tlast marking the final byte of a text, and returns 21-bit code points
// on the rsp_ channel. Each byte is decoded in the cycle it is accepted, and
// its results (zero, one or two) are written into a four-entry result queue,
// which hands out one result per beat. A byte is accepted whenever at least
// two queue entries are free, so with a consumer that never stalls the block
// takes one byte every cycle; a byte that yields two results (a broken
// sequence) adds to the queue's fill, and the queue absorbs that. Malformed
// input (a stray byte, a sequence broken by a non-continuation byte, or a text
// that ends mid-sequence) yields U+FFFD; overlong forms and surrogates are not
// checked. At most min(max_count, MAX_CHARS, 256) code points are returned per
// text; if the final byte then produces nothing, a bare end marker beat with
// code point 0 and tuser set closes the text. max_count is written through the
// csr_ port, resets to 256 and is registered before it takes effect. All
// decode state returns to idle after the final byte of a text.
module utf8_to_codepoint_decoder #(
   parameter int MAX_CHARS = 256
) (
   input  wire                               clock,
   input  wire                               reset,
   // Byte input. tdata: text_byte [7:0]. tlast: final_byte.
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [utf8d_pkg::TEXT_W-1:0]      req_tdata,
   input  wire                               req_tlast,
   // Results. tdata: code_point [20:0], position [28:21], zero fill [31:29].
   // tlast: end_of_text. tuser: end_marker_only.
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [utf8d_pkg::DATA_W-1:0]      rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tuser,
   // Configuration: max_count.
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [utf8d_pkg::COUNT_W-1:0]     csr_data
);
   import utf8d_pkg::*;

   // The cap never exceeds 256, so the position field cannot wrap.
   localparam int              CapLim  = (MAX_CHARS < 256) ? MAX_CHARS : 256;
   localparam logic [COUNT_W-1:0] CAP_LIM = COUNT_W'(CapLim);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   logic [COUNT_W-1:0] max_count_ff, max_count_in;
   logic [CP_W-1:0]    partial_ff, partial_in;
   logic [1:0]         remain_ff, remain_in;
   logic [COUNT_W-1:0] emitted_ff, emitted_in;

   result_type         queue_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    fill_ff, fill_in;

   logic               req_fire, rsp_fire;
   logic [7:0]         b;
   logic               fin;
   logic [COUNT_W-1:0] cap;

   logic               in_seq, is_cont, broken, cont_done, lead_active;
   logic               is_ascii, is_lead2, is_lead3, is_lead4, is_bad, lead_multi;
   logic [1:0]         remain_after;
   logic               truncated;
   logic [CP_W-1:0]    cont_code;
   logic [CP_W-1:0]    lead_code;

   logic               want_a, want_b, put_a, put_b, marker;
   logic [CP_W-1:0]    val_a, val_b;
   logic [COUNT_W-1:0] count_a;
   logic [1:0]         push_n;
   result_type         entry0, entry1;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign csr_ready = 1'b1;

   assign b   = req_tdata;
   assign fin = req_tlast;
   assign cap = (max_count_ff < CAP_LIM) ? max_count_ff : CAP_LIM;

   // Byte classification against the current sequence state.
   always_comb begin
      in_seq      = (remain_ff != 2'd0);
      is_cont     = ((b & CONT_MASK) == CONT_PAT);
      broken      = in_seq && !is_cont;
      cont_done   = in_seq && is_cont && (remain_ff == 2'd1);
      lead_active = !in_seq || broken;

      is_ascii   = lead_active && ((b & ASCII_MASK) == 8'h00);
      is_lead2   = lead_active && ((b & LEAD2_MASK) == LEAD2_PAT);
      is_lead3   = lead_active && ((b & LEAD3_MASK) == LEAD3_PAT);
      is_lead4   = lead_active && ((b & LEAD4_MASK) == LEAD4_PAT);
      lead_multi = is_lead2 || is_lead3 || is_lead4;
      is_bad     = lead_active && !is_ascii && !lead_multi;

      cont_code = {partial_ff[CP_W-7:0], b[5:0] & CONT_BITS[5:0]};

      priority if (is_lead2) begin
         lead_code    = CP_W'(b & LEAD2_BITS);
         remain_after = 2'd1;
      end else if (is_lead3) begin
         lead_code    = CP_W'(b & LEAD3_BITS);
         remain_after = 2'd2;
      end else if (is_lead4) begin
         lead_code    = CP_W'(b & LEAD4_BITS);
         remain_after = 2'd3;
      end else if (in_seq && is_cont) begin
         lead_code    = '0;
         remain_after = remain_ff - 2'd1;
      end else begin
         lead_code    = '0;
         remain_after = 2'd0;
      end

      truncated = fin && (remain_after != 2'd0);
   end

   // At most two code points are attempted per byte: a broken sequence's
   // replacement, then whatever the byte itself yields as a fresh lead.
   always_comb begin
      want_a = broken || cont_done || is_ascii || is_bad || truncated;
      priority if (broken)       val_a = REPL_CP;
      else if (cont_done)        val_a = cont_code;
      else if (is_ascii)         val_a = CP_W'(b);
      else                       val_a = REPL_CP;

      want_b = broken && (is_ascii || is_bad || truncated);
      val_b  = is_ascii ? CP_W'(b) : REPL_CP;

      put_a   = want_a && (emitted_ff < cap);
      count_a = emitted_ff + COUNT_W'(put_a);
      put_b   = want_b && (count_a < cap);

      // Nothing left to report on the final byte: send the end marker alone.
      marker = fin && !put_a;

      entry0.end_marker_only = marker;
      entry0.end_of_text     = fin && !put_b;
      entry0.position        = marker ? '0 : emitted_ff[POS_W-1:0];
      entry0.code_point      = marker ? '0 : val_a;

      entry1.end_marker_only = 1'b0;
      entry1.end_of_text     = fin;
      entry1.position        = count_a[POS_W-1:0];
      entry1.code_point      = val_b;

      if (marker) begin
         push_n = 2'd1;
      end else begin
         push_n = {1'b0, put_a} + {1'b0, put_b};
      end
   end

   // Decode state for the next byte.
   always_comb begin
      max_count_in = csr_valid ? csr_data : max_count_ff;
      partial_in   = partial_ff;
      remain_in    = remain_ff;
      emitted_in   = emitted_ff;
      if (req_fire) begin
         if (fin) begin
            partial_in = '0;
            remain_in  = 2'd0;
            emitted_in = '0;
         end else begin
            remain_in  = remain_after;
            emitted_in = count_a + COUNT_W'(put_b);
            priority if (lead_multi)    partial_in = lead_code;
            else if (in_seq && is_cont) partial_in = cont_done ? '0 : cont_code;
            else                        partial_in = '0;
         end
      end
   end

   // Result queue bookkeeping. Two free entries are kept for every byte.
   always_comb begin
      req_tready = (fill_ff <= (QPTR_W+1)'(QDEPTH - 2));
      rsp_tvalid = (fill_ff != '0);
      wr_ptr_in  = req_fire ? wr_ptr_ff + QPTR_W'(push_n) : wr_ptr_ff;
      rd_ptr_in  = rsp_fire ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in    = fill_ff + (req_fire ? (QPTR_W+1)'(push_n) : '0)
                           - (QPTR_W+1)'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= COUNT_W'(256);
         partial_ff   <= '0;
         remain_ff    <= 2'd0;
         emitted_ff   <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
      end else begin
         max_count_ff <= max_count_in;
         partial_ff   <= partial_in;
         remain_ff    <= remain_in;
         emitted_ff   <= emitted_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
      end
   end

   // Queue payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire && (push_n != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= entry0;
      end
      if (req_fire && (push_n == 2'd2)) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= entry1;
      end
   end

   always_comb begin
      rsp_tdata = {(DATA_W-POS_W-CP_W)'(0), queue_ff[rd_ptr_ff].position,
                   queue_ff[rd_ptr_ff].code_point};
      rsp_tlast = queue_ff[rd_ptr_ff].end_of_text;
      rsp_tuser = queue_ff[rd_ptr_ff].end_marker_only;
   end

endmodule

`default_nettype wire

// File: sv/utf8d_checker.sv
`default_nettype none

module utf8d_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           rsp_tvalid,
   input wire                           rsp_tready,
   input wire [utf8d_pkg::DATA_W-1:0]   rsp_tdata,
   input wire                           rsp_tlast,
   input wire                           rsp_tuser
);
   import utf8d_pkg::*;

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // An end marker beat closes its text and carries no code point.
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("malformed end marker beat");

   // The fill bits above the position field are always zero.
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DATA_W-1:POS_W+CP_W] == '0))
      else $error("nonzero fill bits in result beat");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind utf8_to_codepoint_decoder utf8d_checker u_utf8d_checker (.*);

`default_nettype wire
